FILE: rtl/core/rbf_pkg.sv
// Shared types and constants for the byte ring FIFO with peek.
package rbf_pkg;

	localparam int DepthDefault = 256;

	typedef enum logic [1:0] {
		OP_PUSH    = 2'd0,
		OP_POP     = 2'd1,
		OP_PEEK    = 2'd2,
		OP_DISCARD = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_OFFSET = 2'd3
	} status_t;

	// Outcome of one operation as decided at accept time.
	typedef struct packed {
		status_t     status;
		logic        rd_ok;
		logic [7:0]  fill;
		logic [7:0]  free;
	} res_t;

endpackage

FILE: rtl/core/rbf_mem.sv
// Byte storage of the ring: one write port, one registered read port.
module rbf_mem #(
	parameter int DEPTH = rbf_pkg::DepthDefault,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);
	import rbf_pkg::*;

	logic [7:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/core/rbf_ptr.sv
// Pointer and fill bookkeeping: decodes the operation, checks it, and drives the storage.
module rbf_ptr #(
	parameter int DEPTH = rbf_pkg::DepthDefault,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  rbf_pkg::op_t       op,
	input  logic [7:0]         amount,
	output logic               mem_we,
	output logic [AW-1:0]      mem_waddr,
	output logic               mem_re,
	output logic [AW-1:0]      mem_raddr,
	output rbf_pkg::res_t      res
);
	import rbf_pkg::*;

	localparam int WW = ((AW > 8) ? AW : 8) + 1;

	logic [AW-1:0] rp_q, wp_q, fill_q;
	logic [AW-1:0] rp_n, wp_n, fill_n;
	logic [WW-1:0] amt_w, fill_w, off_sum, off_wrap, fn_w, free_w;
	logic [AW-1:0] rp_inc, wp_inc;
	logic          we_c, re_c;
	status_t       st_c;

	assign amt_w    = WW'(amount);
	assign fill_w   = WW'(fill_q);
	assign off_sum  = WW'(rp_q) + amt_w;
	assign off_wrap = (off_sum >= WW'(DEPTH)) ? off_sum - WW'(DEPTH) : off_sum;
	assign rp_inc   = (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
	assign wp_inc   = (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;

	always_comb begin
		rp_n      = rp_q;
		wp_n      = wp_q;
		fill_n    = fill_q;
		we_c      = 1'b0;
		re_c      = 1'b0;
		st_c      = ST_OK;
		mem_raddr = rp_q;
		unique case (op)
			OP_PUSH: begin
				if (fill_q == AW'(DEPTH - 1)) begin
					st_c = ST_FULL;
				end else begin
					we_c   = 1'b1;
					wp_n   = wp_inc;
					fill_n = fill_q + 1'b1;
				end
			end
			OP_POP: begin
				if (fill_q == '0) begin
					st_c = ST_EMPTY;
				end else begin
					re_c   = 1'b1;
					rp_n   = rp_inc;
					fill_n = fill_q - 1'b1;
				end
			end
			OP_PEEK: begin
				mem_raddr = AW'(off_wrap);
				if (fill_q == '0 || amt_w >= fill_w) begin
					st_c = ST_OFFSET;
				end else begin
					re_c = 1'b1;
				end
			end
			OP_DISCARD: begin
				if (fill_q == '0 || amt_w > fill_w) begin
					st_c = ST_OFFSET;
				end else begin
					rp_n   = AW'(off_wrap);
					fill_n = AW'(fill_w - amt_w);
				end
			end
			default: begin
				st_c = ST_OK;
			end
		endcase
	end

	assign fn_w   = WW'(fill_n);
	assign free_w = WW'(DEPTH - 1) - fn_w;

	assign mem_we    = accept && we_c;
	assign mem_waddr = wp_q;
	assign mem_re    = accept && re_c;

	assign res.status = st_c;
	assign res.rd_ok  = re_c;
	assign res.fill   = (fn_w > WW'(255)) ? 8'hFF : fn_w[7:0];
	assign res.free   = (free_w > WW'(255)) ? 8'hFF : free_w[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q   <= '0;
			wp_q   <= '0;
			fill_q <= '0;
		end else if (accept) begin
			rp_q   <= rp_n;
			wp_q   <= wp_n;
			fill_q <= fill_n;
		end
	end

endmodule

FILE: rtl/core/byte_ring_fifo_with_peek.sv
// Top level of the byte ring FIFO with push, pop, peek and discard.
// The result of an item is presented in the cycle after it is accepted.
// Throughput: one item per cycle while the output is not stalled; pointers and fill
// update at accept, and the single storage read port returns its byte into the output stage.
// in_ready is low only while a finished result waits and out_ready is low.
// Reset (arst_n low) empties the ring; storage contents are not cleared.
module byte_ring_fifo_with_peek #(
	parameter int DEPTH = rbf_pkg::DepthDefault
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] op,
	input  logic [7:0] write_byte,
	input  logic [7:0] amount,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] status,
	output logic [7:0] read_byte,
	output logic [7:0] fill_count,
	output logic [7:0] free_count
);
	import rbf_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic          accept;
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [7:0]    mem_rdata;
	res_t          res;

	// Output stage holding the result of the last accepted item.
	logic          out_valid_q;
	res_t          res_s1;

	// Take a new item whenever the output stage is free or drains this cycle.
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	rbf_ptr #(.DEPTH(DEPTH)) u_ptr (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.op        (op_t'(op)),
		.amount    (amount),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.res       (res)
	);

	// Read data only loads on an accepted pop or peek, so it holds while stalled.
	rbf_mem #(.DEPTH(DEPTH)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (write_byte),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hold the payload until the next accepted item replaces it.
	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = res_s1.status;
	assign read_byte  = res_s1.rd_ok ? mem_rdata : 8'h00;
	assign fill_count = res_s1.fill;
	assign free_count = res_s1.free;

endmodule

FILE: rtl/core/rbf_chk.sv
// Port-level assertion checker for the byte ring FIFO, with its bind.
module rbf_chk #(
	parameter int DEPTH = rbf_pkg::DepthDefault
) (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] status,
	input logic [7:0] read_byte,
	input logic [7:0] fill_count,
	input logic [7:0] free_count
);
	import rbf_pkg::*;

	localparam int CapW = 17;
	localparam logic [CapW-1:0] Cap = CapW'(DEPTH - 1);

	// An accepted item presents its result on the next cycle.
	a_in_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted item produced no result");

	// A waiting result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// Fill and free always add up to the capacity unless one saturates.
	a_count_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (fill_count == 8'hFF || free_count == 8'hFF ||
		(CapW'(fill_count) + CapW'(free_count)) == Cap))
		else $error("fill and free counts inconsistent");

	// A failed operation reads no byte.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> read_byte == 8'h00)
		else $error("byte returned on failed operation");

	// Full and empty reports agree with the counts.
	a_full_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status != ST_FULL || free_count == 8'h00) &&
		(status != ST_EMPTY || fill_count == 8'h00))
		else $error("status disagrees with counts");

endmodule

bind byte_ring_fifo_with_peek rbf_chk #(.DEPTH(DEPTH)) u_rbf_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.status     (status),
	.read_byte  (read_byte),
	.fill_count (fill_count),
	.free_count (free_count)
);

FILE: test/byte_ring_fifo_with_peek_checker.sv
// Result predictor and checker for the byte ring FIFO with peek.
module byte_ring_fifo_with_peek_checker #(
	parameter int DEPTH = rbf_pkg::DepthDefault
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [1:0] op,
	input  logic [7:0] write_byte,
	input  logic [7:0] amount,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [1:0] status,
	input  logic [7:0] read_byte,
	input  logic [7:0] fill_count,
	input  logic [7:0] free_count,
	output int         mismatches,
	output int         owed,
	output int         results_seen,
	output int         full_seen,
	output int         empty_seen,
	output int         offset_seen,
	output int         peak_fill
);
	import rbf_pkg::*;

	typedef struct packed {
		status_t    status;
		logic [7:0] read_byte;
		logic [7:0] fill;
		logic [7:0] free;
	} ring_result_t;

	logic [7:0]   ring_mem [DEPTH];
	int           head;
	int           tail;
	int           bad;
	ring_result_t owed_results [$];
	ring_result_t want;
	ring_result_t next_result;

	function automatic logic [7:0] clip8(int v);
		return (v > 255) ? 8'd255 : 8'(v);
	endfunction

	// Apply one operation to the shadow ring and return the result it yields.
	function automatic ring_result_t ring_apply(op_t kind, logic [7:0] wb, logic [7:0] amt);
		ring_result_t r;
		int held;
		held = (tail + DEPTH - head) % DEPTH;
		r.status = ST_OK;
		r.read_byte = 8'd0;
		case (kind)
			OP_PUSH: begin
				if (held >= DEPTH - 1) begin
					r.status = ST_FULL;
				end else begin
					ring_mem[tail] = wb;
					tail = (tail + 1) % DEPTH;
				end
			end
			OP_POP: begin
				if (held == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.read_byte = ring_mem[head];
					head = (head + 1) % DEPTH;
				end
			end
			OP_PEEK: begin
				if (held == 0 || int'(amt) >= held) begin
					r.status = ST_OFFSET;
				end else begin
					r.read_byte = ring_mem[(head + int'(amt)) % DEPTH];
				end
			end
			default: begin
				if (held == 0 || int'(amt) > held) begin
					r.status = ST_OFFSET;
				end else begin
					head = (head + int'(amt)) % DEPTH;
				end
			end
		endcase
		held = (tail + DEPTH - head) % DEPTH;
		if (held > peak_fill)
			peak_fill = held;
		r.fill = clip8(held);
		r.free = clip8(DEPTH - 1 - held);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed_results.delete();
			head = 0;
			tail = 0;
			bad = 0;
			results_seen = 0;
			full_seen = 0;
			empty_seen = 0;
			offset_seen = 0;
			peak_fill = 0;
			mismatches <= 0;
			owed <= 0;
		end else begin
			// Results leave no earlier than the cycle after their item, so check first.
			if (out_valid && out_ready) begin
				if (owed_results.size() == 0) begin
					$error("result with no item pending: status %0d read_byte %0d",
						status, read_byte);
					bad++;
				end else begin
					want = owed_results.pop_front();
					results_seen++;
					case (status_t'(status))
						ST_FULL:   full_seen++;
						ST_EMPTY:  empty_seen++;
						ST_OFFSET: offset_seen++;
						default: ;
					endcase
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						bad++;
					end
					if (read_byte !== want.read_byte) begin
						$error("read_byte: expected %0d, got %0d", want.read_byte, read_byte);
						bad++;
					end
					if (fill_count !== want.fill) begin
						$error("fill_count: expected %0d, got %0d", want.fill, fill_count);
						bad++;
					end
					if (free_count !== want.free) begin
						$error("free_count: expected %0d, got %0d", want.free, free_count);
						bad++;
					end
				end
			end
			if (in_valid && in_ready) begin
				next_result = ring_apply(op_t'(op), write_byte, amount);
				owed_results.push_back(next_result);
			end
			mismatches <= bad;
			owed <= owed_results.size();
		end
	end

endmodule

FILE: test/byte_ring_fifo_with_peek_tb.sv
// Testbench top for the byte ring FIFO with peek: stimulus, reset and verdict.
module byte_ring_fifo_with_peek_tb;
	import rbf_pkg::*;

	// Traffic shapes for the random part of the run.
	typedef enum {
		PH_FILL,
		PH_DRAIN,
		PH_MIX
	} traffic_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] op = OP_PUSH;
	logic [7:0] write_byte = 8'd0;
	logic [7:0] amount = 8'd0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] status;
	logic [7:0] read_byte;
	logic [7:0] fill_count;
	logic [7:0] free_count;

	int mismatches;
	int owed;
	int results_seen;
	int full_seen;
	int empty_seen;
	int offset_seen;
	int peak_fill;

	// Set to suppress idling on the sending or receiving side.
	bit calm_send = 1'b0;
	bit calm_recv = 1'b0;
	int stall_left = 0;
	int stall_roll;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	byte_ring_fifo_with_peek dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.write_byte (write_byte),
		.amount     (amount),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.read_byte  (read_byte),
		.fill_count (fill_count),
		.free_count (free_count)
	);

	byte_ring_fifo_with_peek_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.write_byte   (write_byte),
		.amount       (amount),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.read_byte    (read_byte),
		.fill_count   (fill_count),
		.free_count   (free_count),
		.mismatches   (mismatches),
		.owed         (owed),
		.results_seen (results_seen),
		.full_seen    (full_seen),
		.empty_seen   (empty_seen),
		.offset_seen  (offset_seen),
		.peak_fill    (peak_fill)
	);

	// Receiver: mostly ready, with short stalls and the odd long one.
	always @(posedge clk) begin
		if (calm_recv) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			stall_roll = $urandom_range(0, 99);
			if (stall_roll < 70) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b0;
				stall_left <= (stall_roll < 95) ? $urandom_range(0, 2) : $urandom_range(5, 30);
			end
		end
	end

	// Gap before the next item: usually none, sometimes short, rarely long.
	function automatic int next_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (calm_send || roll < 65)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	// Present one item, hold it until accepted, then idle for the given gap.
	// Called and returning on a rising edge.
	task automatic send_item(op_t kind, logic [7:0] wb, logic [7:0] amt, int gap);
		in_valid <= 1'b1;
		op <= kind;
		write_byte <= wb;
		amount <= amt;
		do
			@(posedge clk);
		while (!in_ready);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop sending and wait until every result owed has come out.
	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (owed != 0);
	endtask

	task automatic run_phase(traffic_t shape, int count);
		int roll;
		op_t kind;
		logic [7:0] amt;
		for (int i = 0; i < count; i++) begin
			roll = $urandom_range(0, 99);
			amt = 8'($urandom_range(0, 255));
			case (shape)
				// Mostly pushes, so the ring reaches full and pushes bounce off.
				PH_FILL: kind = (roll < 88) ? OP_PUSH : OP_PEEK;
				// Empty the ring, then keep hitting the empty cases.
				PH_DRAIN: begin
					if (roll < 50)
						kind = OP_POP;
					else if (roll < 80)
						kind = OP_DISCARD;
					else
						kind = OP_PEEK;
				end
				default: begin
					if (roll < 45)
						kind = OP_PUSH;
					else if (roll < 65)
						kind = OP_POP;
					else if (roll < 85)
						kind = OP_PEEK;
					else
						kind = OP_DISCARD;
				end
			endcase
			// Keep most discards short so they can succeed.
			if (kind == OP_DISCARD && $urandom_range(0, 7) != 0)
				amt = (shape == PH_MIX) ? 8'($urandom_range(0, 4)) : 8'($urandom_range(0, 16));
			send_item(kind, 8'($urandom_range(0, 255)), amt, next_gap());
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty-ring failures, byte extremes, peek and discard bounds.
		send_item(OP_POP,     8'h00, 8'd0,   next_gap());
		send_item(OP_PEEK,    8'h00, 8'd0,   next_gap());
		send_item(OP_DISCARD, 8'h00, 8'd0,   next_gap());
		send_item(OP_PUSH,    8'h00, 8'd0,   next_gap());
		send_item(OP_PUSH,    8'hFF, 8'd255, next_gap());
		send_item(OP_PUSH,    8'hA5, 8'd0,   next_gap());
		send_item(OP_PEEK,    8'h00, 8'd0,   next_gap());
		send_item(OP_PEEK,    8'h00, 8'd2,   next_gap());
		send_item(OP_PEEK,    8'h00, 8'd3,   next_gap());
		send_item(OP_PEEK,    8'hFF, 8'd255, next_gap());
		send_item(OP_DISCARD, 8'h00, 8'd0,   next_gap());
		send_item(OP_DISCARD, 8'h00, 8'd4,   next_gap());
		send_item(OP_POP,     8'h00, 8'd0,   next_gap());
		send_item(OP_DISCARD, 8'h00, 8'd2,   next_gap());
		send_item(OP_PUSH,    8'h5A, 8'd0,   next_gap());
		send_item(OP_DISCARD, 8'h00, 8'd255, next_gap());
		send_item(OP_POP,     8'h00, 8'd0,   next_gap());
		send_item(OP_POP,     8'h00, 8'd0,   next_gap());
		drain_results();

		// Random: fill to full, drain back-to-back without idling, then mix.
		run_phase(PH_FILL, 320);
		calm_send = 1'b1;
		calm_recv = 1'b1;
		run_phase(PH_DRAIN, 180);
		calm_send = 1'b0;
		calm_recv = 1'b0;
		drain_results();
		run_phase(PH_MIX, 300);

		drain_results();
		repeat (5) @(posedge clk);
		$display("covered %0d results: %0d full pushes, %0d empty pops, %0d offset errors",
			results_seen, full_seen, empty_seen, offset_seen);
		$display("highest fill reached %0d bytes; %0d field mismatches", peak_fill, mismatches);
		if (mismatches == 0) begin
			$display("byte_ring_fifo_with_peek verification clean");
		end else begin
			$display("byte_ring_fifo_with_peek verification failed");
		end
		$finish;
	end

	// Hard stop if the handshakes ever hang.
	initial begin
		#2000000;
		$display("byte_ring_fifo_with_peek verification failed");
		$finish;
	end

endmodule
